// ----- sv/cmdtok_pkg.sv -----
`default_nettype none

package cmdtok_pkg;

  // Line and argument limits
  localparam int MAX_ARGS = 16;
  localparam int MAX_LINE = 256;

  // Field widths of the item formats
  localparam int CHAR_W    = 8;
  localparam int ROLE_W    = 3;
  localparam int ARG_NUM_W = 4;
  localparam int CMD_NUM_W = 8;
  localparam int ARG_CNT_W = 5;
  localparam int POS_W     = 8;

  localparam logic [ARG_CNT_W-1:0] ARG_LIMIT = ARG_CNT_W'(MAX_ARGS);
  localparam logic [POS_W-1:0]     POS_LAST  = POS_W'(MAX_LINE - 1);
  localparam logic [CMD_NUM_W-1:0] CMD_MAX   = '1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

  // Role codes
  localparam logic [ROLE_W-1:0] ROLE_BLANK = 3'd0;
  localparam logic [ROLE_W-1:0] ROLE_START = 3'd1;
  localparam logic [ROLE_W-1:0] ROLE_CONT  = 3'd2;
  localparam logic [ROLE_W-1:0] ROLE_SEP   = 3'd3;
  localparam logic [ROLE_W-1:0] ROLE_DROP  = 3'd4;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [ROLE_W-1:0]    role;
    logic [ARG_NUM_W-1:0] arg_number;
    logic [CMD_NUM_W-1:0] command_number;
    logic                 command_done;
    logic [ARG_CNT_W-1:0] command_args;
    logic                 too_long;
    logic                 last;
  } out_item_t;

endpackage

`default_nettype wire

// ----- sv/command_line_tokenizer.sv -----
// Command line tokenizer: labels a command line one character per item.
// Input channel (in_valid / in_stall / in_item): one character and an
// end-of-line mark per item. Result channel (out_valid / out_stall /
// out_item): one labeled result per accepted item, in order, giving the
// character's role, argument and command index, command-end report with
// argument count, the too-long flag and a copy of the end-of-line mark.
// Path: an accepted item enters the input register, is labeled from there,
// and its label is registered in the result register that drives out_.
// Throughput: one item per cycle while out_stall is low; the per-character
// update of the line state (quote, escape, argument and command counters,
// position) is short logic between the input and the result register.
// Stall: while out_stall holds a result, the input register keeps its item
// and in_stall rises only when that register is full and cannot advance;
// up to two items are held inside, none lost or repeated.
// Reset: synchronous, active low; clears both valid bits and returns the
// line state to the start of a fresh line. An item marked end_of_line also
// returns the line state to that start once it is labeled.
`default_nettype none

module command_line_tokenizer (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire cmdtok_pkg::in_item_t  in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output cmdtok_pkg::out_item_t      out_item
);
  import cmdtok_pkg::*;

  // Input register stage
  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r;

  // Result register stage
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  // Line state
  logic                 quotes_r, quotes_nxt;
  logic                 prev_bs_r, prev_bs_nxt;
  logic                 at_start_r, at_start_nxt;
  logic                 in_arg_r, in_arg_nxt;
  logic [ARG_CNT_W-1:0] arg_cnt_r, arg_cnt_nxt;
  logic                 limit_r, limit_nxt;
  logic [CMD_NUM_W-1:0] cmd_cnt_r, cmd_cnt_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;

  logic              advance;
  logic [CHAR_W-1:0] ch;
  logic              is_blank;
  logic              quotes_tgl;
  logic              is_sep;

  // Move the held item on when the result register is empty or being taken
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    s1_valid_nxt = in_stall ? 1'b1 : in_valid;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Per-character labeling and state update
  always_comb begin
    ch         = s1_item_r.char_in;
    is_blank   = (ch == CH_SPACE) || (ch == CH_TAB);
    quotes_tgl = quotes_r ^ ((ch == CH_QUOTE) && !prev_bs_r);
    is_sep     = !quotes_tgl && (ch == CH_SEMI) && !at_start_r && !prev_bs_r;

    quotes_nxt   = quotes_tgl;
    prev_bs_nxt  = prev_bs_r;
    at_start_nxt = at_start_r;
    in_arg_nxt   = in_arg_r;
    arg_cnt_nxt  = arg_cnt_r;
    limit_nxt    = limit_r;
    cmd_cnt_nxt  = cmd_cnt_r;
    pos_nxt      = (pos_r != POS_LAST) ? pos_r + 1'b1 : pos_r;

    out_item_nxt                = '0;
    out_item_nxt.command_number = cmd_cnt_r;
    out_item_nxt.too_long       = (pos_r == POS_LAST);
    out_item_nxt.last           = s1_item_r.end_of_line;

    if (is_sep) begin
      // Close the command and begin a fresh one
      out_item_nxt.role         = ROLE_SEP;
      out_item_nxt.command_done = 1'b1;
      out_item_nxt.command_args = arg_cnt_r;
      if (cmd_cnt_r != CMD_MAX) begin
        cmd_cnt_nxt = cmd_cnt_r + 1'b1;
      end
      quotes_nxt   = 1'b0;
      prev_bs_nxt  = 1'b0;
      at_start_nxt = 1'b1;
      in_arg_nxt   = 1'b0;
      arg_cnt_nxt  = '0;
      limit_nxt    = 1'b0;
    end else begin
      if (is_blank) begin
        out_item_nxt.role = limit_r ? ROLE_DROP : ROLE_BLANK;
        if (in_arg_r) begin
          in_arg_nxt = 1'b0;
          if (arg_cnt_r >= ARG_LIMIT) begin
            limit_nxt = 1'b1;
          end
        end
      end else if (limit_r) begin
        out_item_nxt.role = ROLE_DROP;
      end else if (in_arg_r) begin
        out_item_nxt.role       = ROLE_CONT;
        out_item_nxt.arg_number = ARG_NUM_W'(arg_cnt_r - 1'b1);
      end else begin
        out_item_nxt.role       = ROLE_START;
        out_item_nxt.arg_number = ARG_NUM_W'(arg_cnt_r);
        arg_cnt_nxt             = arg_cnt_r + 1'b1;
        in_arg_nxt              = 1'b1;
      end
      at_start_nxt = 1'b0;
      prev_bs_nxt  = (ch == CH_BSLASH);
      if (s1_item_r.end_of_line) begin
        out_item_nxt.command_done = 1'b1;
        out_item_nxt.command_args = arg_cnt_nxt;
      end
    end

    // Drop all line state after the last character
    if (s1_item_r.end_of_line) begin
      quotes_nxt   = 1'b0;
      prev_bs_nxt  = 1'b0;
      at_start_nxt = 1'b1;
      in_arg_nxt   = 1'b0;
      arg_cnt_nxt  = '0;
      limit_nxt    = 1'b0;
      cmd_cnt_nxt  = '0;
      pos_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      quotes_r    <= 1'b0;
      prev_bs_r   <= 1'b0;
      at_start_r  <= 1'b1;
      in_arg_r    <= 1'b0;
      arg_cnt_r   <= '0;
      limit_r     <= 1'b0;
      cmd_cnt_r   <= '0;
      pos_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        quotes_r   <= quotes_nxt;
        prev_bs_r  <= prev_bs_nxt;
        at_start_r <= at_start_nxt;
        in_arg_r   <= in_arg_nxt;
        arg_cnt_r  <= arg_cnt_nxt;
        limit_r    <= limit_nxt;
        cmd_cnt_r  <= cmd_cnt_nxt;
        pos_r      <= pos_nxt;
      end
    end
  end

  // Payload registers: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Argument count never runs past the limit
  assert property (@(posedge clk) disable iff (!rst_n)
    arg_cnt_r <= ARG_LIMIT)
    else $error("argument count beyond limit");

  // A result that ends no command reports no argument count
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.command_done) |-> (out_item_r.command_args == '0))
    else $error("argument count without command end");

  // A separator always ends a command
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.role == ROLE_SEP)) |-> out_item_r.command_done)
    else $error("separator without command end");

  // The last character of a line leaves a fresh line state
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_item_r.end_of_line) |=>
      (pos_r == '0 && cmd_cnt_r == '0 && at_start_r && !limit_r))
    else $error("line state not cleared after line end");

endmodule

`default_nettype wire

// ----- tb/command_line_tokenizer_tb.sv -----
`timescale 1ns / 1ps

module command_line_tokenizer_tb;
  import cmdtok_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEM_TARGET = 1150;  // includes one long saturation line
  localparam int unsigned HOLD_AT     = 400;   // item count that triggers the long hold-off
  localparam int unsigned CALM_FROM   = 1000;  // no idling on either side from here
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Label every accepted character the way the block should and keep the
  // labels in order until the matching result shows up.
  class char_labeler;
    out_item_t labels_due[$];
    int unsigned mismatches;
    int unsigned labels_seen;
    bit quoted, escaped, cmd_start, in_arg, limit_hit;
    logic [ARG_CNT_W-1:0] nargs;
    logic [CMD_NUM_W-1:0] cmd_idx;
    int unsigned pos;

    function void fresh_command();
      quoted    = 1'b0;
      escaped   = 1'b0;
      cmd_start = 1'b1;
      in_arg    = 1'b0;
      nargs     = '0;
      limit_hit = 1'b0;
    endfunction

    function void fresh_line();
      fresh_command();
      cmd_idx = '0;
      pos     = 0;
    endfunction

    function void take_char(in_item_t it);
      out_item_t lab;
      logic [CHAR_W-1:0] ch;
      bit blank;
      ch = it.char_in;
      lab = '0;
      lab.command_number = cmd_idx;
      lab.too_long = (pos >= MAX_LINE - 1);
      lab.last = it.end_of_line;
      if (pos < MAX_LINE - 1) pos++;
      // An unescaped quote flips the quoted state before the separator test.
      if (ch == CH_QUOTE && !escaped) quoted = !quoted;
      if (!quoted && ch == CH_SEMI && !cmd_start && !escaped) begin
        lab.role = ROLE_SEP;
        lab.command_done = 1'b1;
        lab.command_args = nargs;
        if (cmd_idx != CMD_MAX) cmd_idx++;
        fresh_command();
      end else begin
        blank = (ch == CH_SPACE || ch == CH_TAB);
        if (blank) begin
          lab.role = limit_hit ? ROLE_DROP : ROLE_BLANK;
          if (in_arg) begin
            in_arg = 1'b0;
            if (nargs >= ARG_LIMIT) limit_hit = 1'b1;
          end
        end else if (limit_hit) begin
          lab.role = ROLE_DROP;
        end else if (in_arg) begin
          lab.role = ROLE_CONT;
          lab.arg_number = ARG_NUM_W'(nargs - 1);
        end else begin
          nargs++;
          in_arg = 1'b1;
          lab.role = ROLE_START;
          lab.arg_number = ARG_NUM_W'(nargs - 1);
        end
        cmd_start = 1'b0;
        escaped = (ch == CH_BSLASH);
        if (it.end_of_line) begin
          lab.command_done = 1'b1;
          lab.command_args = nargs;
        end
      end
      if (it.end_of_line) fresh_line();
      labels_due.push_back(lab);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch at result %0d: %s", labels_seen, what);
    endtask

    task check_label(out_item_t got);
      out_item_t want;
      if (labels_due.size() == 0) begin
        report_mismatch("result with no character waiting");
        return;
      end
      want = labels_due.pop_front();
      if (got.role !== want.role)
        report_mismatch($sformatf("role %0d, want %0d", got.role, want.role));
      if (got.arg_number !== want.arg_number)
        report_mismatch($sformatf("arg_number %0d, want %0d",
                                  got.arg_number, want.arg_number));
      if (got.command_number !== want.command_number)
        report_mismatch($sformatf("command_number %0d, want %0d",
                                  got.command_number, want.command_number));
      if (got.command_done !== want.command_done)
        report_mismatch($sformatf("command_done %0d, want %0d",
                                  got.command_done, want.command_done));
      if (got.command_args !== want.command_args)
        report_mismatch($sformatf("command_args %0d, want %0d",
                                  got.command_args, want.command_args));
      if (got.too_long !== want.too_long)
        report_mismatch($sformatf("too_long %0d, want %0d", got.too_long, want.too_long));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
      labels_seen++;
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  char_labeler lab;
  logic [CHAR_W-1:0] line_chars[$];
  int unsigned items_sent;
  int unsigned cycle_count;
  bit hold_req;
  bit hold_done;
  bit calm;

  command_line_tokenizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Sample both channels at the edge; every input is driven by nonblocking
  // assignment, so these see the values that the block sees.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) lab.take_char(in_item);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) lab.check_label(out_item);
  end

  // Stop a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Receiver: stall in short random bursts, hold off once for a long
  // stretch so the block fills up, and drain freely near the end.
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Offer one character, optionally after a gap, and hold it until taken.
  task automatic send_item(in_item_t it);
    calm = (items_sent >= CALM_FROM);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Send the buffered line, marking its last character as end of line.
  task automatic send_line();
    in_item_t it;
    if (line_chars.size() == 0) line_chars.push_back("q");
    foreach (line_chars[i]) begin
      it.char_in     = line_chars[i];
      it.end_of_line = (i == line_chars.size() - 1);
      send_item(it);
    end
    line_chars.delete();
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
  endfunction

  function automatic void add_blank();
    line_chars.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  // Mostly letters, with the odd quote, backslash, semicolon or raw byte.
  function automatic logic [CHAR_W-1:0] word_char();
    case ($urandom_range(0, 11))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SEMI;
      3, 4: return CHAR_W'($urandom_range(1, 255));
      default: return CHAR_W'(8'h61 + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic void add_command(int unsigned n_args);
    repeat ($urandom_range(0, 2)) add_blank();
    for (int a = 0; a < n_args; a++) begin
      repeat ($urandom_range(1, 4)) line_chars.push_back(word_char());
      repeat ($urandom_range(1, 2)) add_blank();
    end
    // Drop the trailing blanks half the time so the command ends inside a word.
    if ($urandom_range(0, 1) && n_args != 0) begin
      while (line_chars.size() != 0 &&
             (line_chars[$] == CH_SPACE || line_chars[$] == CH_TAB))
        void'(line_chars.pop_back());
    end
  endfunction

  // Well-formed line: a few commands, some of them past the argument limit.
  function automatic void build_command_line();
    int unsigned n_cmds;
    n_cmds = $urandom_range(1, 4);
    for (int c = 0; c < n_cmds; c++) begin
      add_command(($urandom_range(0, 4) == 0) ? $urandom_range(14, 20)
                                               : $urandom_range(0, 5));
      if (c != n_cmds - 1 || $urandom_range(0, 3) == 0) line_chars.push_back(CH_SEMI);
    end
  endfunction

  function automatic void build_noise_line();
    repeat ($urandom_range(1, 24)) begin
      case ($urandom_range(0, 5))
        0: add_blank();
        1: line_chars.push_back(CH_SEMI);
        2: line_chars.push_back(CH_QUOTE);
        3: line_chars.push_back(CH_BSLASH);
        default: line_chars.push_back(CHAR_W'($urandom_range(1, 255)));
      endcase
    end
  endfunction

  // Straddle the length limit: just short of it, right at it, or past it.
  function automatic void build_long_line();
    int unsigned target;
    target = $urandom_range(MAX_LINE - 2, MAX_LINE + 40);
    while (line_chars.size() < target) begin
      case ($urandom_range(0, 19))
        0: line_chars.push_back(CH_SEMI);
        1, 2, 3, 4, 5: add_blank();
        default: line_chars.push_back(word_char());
      endcase
    end
  endfunction

  initial begin
    int unsigned line_no;
    lab = new;
    lab.fresh_line();
    items_sent = 0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    calm       = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Semicolon at command start, escaped, quoted, a real separator, a second
    // one right after it, tab, the extreme byte values, and a final word.
    push_text(";a\\; 'x;y';;");
    line_chars.push_back(CH_TAB);
    line_chars.push_back(8'hFF);
    line_chars.push_back(8'h01);
    push_text(";z");
    send_line();
    // Separator as the last character: ends the command once.
    push_text("a;");
    send_line();
    // Empty command.
    add_blank();
    send_line();
    // Lone quote at command start.
    line_chars.push_back(CH_QUOTE);
    send_line();

    line_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (line_no == 3) begin
        // Enough separators to run the command counter into saturation.
        repeat (int'(CMD_MAX) + 2) begin
          line_chars.push_back("x");
          line_chars.push_back(CH_SEMI);
        end
        line_chars.push_back("y");
      end else if (line_no % 25 == 8) begin
        build_long_line();
      end else if ($urandom_range(0, 6) == 0) begin
        build_noise_line();
      end else begin
        build_command_line();
      end
      send_line();
      line_no++;
    end

    // Drop valid and let every outstanding label come back.
    in_valid <= 1'b0;
    while (lab.labels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lab.mismatches == 0 && lab.labels_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/cmdtok_pkg.sv
sv/command_line_tokenizer.sv
tb/command_line_tokenizer_tb.sv
